// File: sv/saa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types and constants of the slave alarm annunciator.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int unsigned MAX_SLAVES_DEF = 8;
  localparam int unsigned REG_WIDTH_DEF  = 16;

  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_REG_W = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SCNT_W   = 4;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Register 0 value that marks a healthy slave.
  localparam int unsigned OK_VALUE = 4;

  localparam logic [SCNT_W-1:0] SLAVE_COUNT_RST   = 4'd3;
  localparam logic [CNT_W-1:0]  DEBOUNCE_TICKS_RST = 16'd50;
  localparam logic [CNT_W-1:0]  BLINK_TICKS_RST    = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS    = 2'd2;

  localparam logic CMD_POLL = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_UNACK  = 2'd1,
    ST_ACK    = 2'd2
  } alarm_e;

  typedef struct packed {
    logic                cmd;
    logic [IDX_W-1:0]    slave_index;
    logic                link_ok;
    logic [IN_REG_W-1:0] reg_value;
    logic                reset_pin;
  } in_t;

  typedef struct packed {
    logic [MASK_W-1:0] led_on_mask;
    logic              buzzer_on;
    logic              bell_active;
    logic              reset_active;
    logic [1:0]        slave_state;
  } out_t;

  // Common control broadcast to every slave lane.
  typedef struct packed {
    logic                update;
    logic                link_ok;
    logic [IN_REG_W-1:0] reg_value;
    logic                ack;
    logic                blink;
  } lane_ctrl_t;

endpackage

// File: sv/saa_slave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saa_slave
// State of one monitored slave: alarm state, last link and last register 0.
// ----------------------------------------------------------------------------
module saa_slave #(
  parameter int unsigned REG_WIDTH = saa_pkg::REG_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  saa_pkg::lane_ctrl_t ctrl_i,
  input  logic                sel_i,
  input  logic                enabled_i,
  output saa_pkg::alarm_e     state_d_o,
  output logic                raise_o,
  output logic                lit_o
);

  localparam int unsigned UseW =
    (REG_WIDTH < saa_pkg::IN_REG_W) ? REG_WIDTH : saa_pkg::IN_REG_W;

  saa_pkg::alarm_e        state_q, state_d, state_raised, state_acked;
  logic                   link_q, link_d;
  logic [REG_WIDTH-1:0]   reg_q, reg_d, reg_new;
  logic                   hit;
  logic                   link_fall;
  logic                   reg_fall;

  always_comb begin
    reg_new   = REG_WIDTH'(ctrl_i.reg_value[UseW-1:0]);
    hit       = ctrl_i.update & sel_i;
    link_fall = link_q & ~ctrl_i.link_ok;
    reg_fall  = |(~reg_new & reg_q);
    raise_o   = hit & (link_fall | reg_fall);

    state_raised = raise_o ? saa_pkg::ST_UNACK : state_q;
    link_d       = hit ? ctrl_i.link_ok : link_q;
    reg_d        = hit ? reg_new : reg_q;

    state_acked = state_raised;
    if (enabled_i && ctrl_i.ack && state_raised == saa_pkg::ST_UNACK) begin
      state_acked = saa_pkg::ST_ACK;
    end
    state_d = state_acked;
    if (enabled_i && state_acked == saa_pkg::ST_ACK && link_d &&
        reg_d == REG_WIDTH'(saa_pkg::OK_VALUE)) begin
      state_d = saa_pkg::ST_NORMAL;
    end

    state_d_o = state_d;
    lit_o     = enabled_i & ((state_d == saa_pkg::ST_UNACK && ctrl_i.blink) ||
                             state_d == saa_pkg::ST_ACK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= saa_pkg::ST_NORMAL;
      link_q  <= 1'b0;
      reg_q   <= '0;
    end else if (ctrl_i.update) begin
      state_q <= state_d;
      link_q  <= link_d;
      reg_q   <= reg_d;
    end
  end

endmodule

// File: sv/slave_alarm_annunciator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slave_alarm_annunciator
// Alarm annunciator for polled slaves with debounced acknowledge and blink.
// ----------------------------------------------------------------------------
// A word is held in the input register and then passes to the result register.
// Throughput: one word per cycle; the input register and the result register
// each move on when the result register is empty or being taken.
// Reset clears all slave states, the bell and the debounce flag, and loads
// the register defaults; counters start at their default periods.
module slave_alarm_annunciator #(
  parameter int unsigned MAX_SLAVES = saa_pkg::MAX_SLAVES_DEF,
  parameter int unsigned REG_WIDTH  = saa_pkg::REG_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  saa_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output saa_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [saa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [saa_pkg::CNT_W-1:0]         cfg_data_i
);

  localparam int unsigned NW =
    $clog2(((MAX_SLAVES > 15) ? MAX_SLAVES : 15) + 1);

  // Configuration registers.
  logic [saa_pkg::SCNT_W-1:0] slave_count_q;
  logic [saa_pkg::CNT_W-1:0]  debounce_ticks_q;
  logic [saa_pkg::CNT_W-1:0]  blink_ticks_q;

  // Input stage and result stage.
  logic          item_valid_q;
  saa_pkg::in_t  item_q;
  logic          out_valid_q;
  saa_pkg::out_t out_q;
  logic          advance;
  logic          update;

  // Global state.
  logic                      bell_q, bell_d;
  logic                      flag_q, flag_d;
  logic [saa_pkg::CNT_W-1:0] debounce_q, debounce_d;
  logic [saa_pkg::CNT_W-1:0] blink_q, blink_d;
  logic [1:0]                phase_q, phase_d;

  logic [NW-1:0]         active_n;
  logic                  is_tick;
  logic                  idx_active;
  saa_pkg::lane_ctrl_t   ctrl;
  saa_pkg::alarm_e       lane_state [MAX_SLAVES];
  logic [MAX_SLAVES-1:0] lane_raise;
  logic [MAX_SLAVES-1:0] lane_lit;
  logic [MAX_SLAVES-1:0] lane_sel;
  logic [MAX_SLAVES-1:0] lane_en;
  logic [saa_pkg::MASK_W-1:0] mask;
  logic [1:0]            st_sel;

  assign advance     = ~out_valid_q | out_ready_i;
  assign update      = item_valid_q & advance;
  assign in_ready_o  = ~item_valid_q | advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_count_q    <= saa_pkg::SLAVE_COUNT_RST;
      debounce_ticks_q <= saa_pkg::DEBOUNCE_TICKS_RST;
      blink_ticks_q    <= saa_pkg::BLINK_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        saa_pkg::CFG_SLAVE_COUNT:    slave_count_q <= cfg_data_i[saa_pkg::SCNT_W-1:0];
        saa_pkg::CFG_DEBOUNCE_TICKS: debounce_ticks_q <= cfg_data_i;
        saa_pkg::CFG_BLINK_TICKS:    blink_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    active_n = (NW'(slave_count_q) > NW'(MAX_SLAVES)) ? NW'(MAX_SLAVES)
                                                      : NW'(slave_count_q);
    is_tick    = (item_q.cmd == saa_pkg::CMD_TICK);
    idx_active = NW'(item_q.slave_index) < active_n;

    blink_d = blink_q;
    phase_d = phase_q;
    debounce_d = debounce_q;
    flag_d  = flag_q;
    if (is_tick) begin
      if (blink_q <= saa_pkg::CNT_W'(1)) begin
        blink_d = blink_ticks_q;
        phase_d = phase_q + 2'd1;
      end else begin
        blink_d = blink_q - saa_pkg::CNT_W'(1);
      end
      if (item_q.reset_pin) begin
        if (debounce_q <= saa_pkg::CNT_W'(1)) begin
          debounce_d = debounce_ticks_q;
          flag_d     = 1'b1;
        end else begin
          debounce_d = debounce_q - saa_pkg::CNT_W'(1);
        end
      end else begin
        debounce_d = debounce_ticks_q;
        flag_d     = 1'b0;
      end
    end

    ctrl.update    = update;
    ctrl.link_ok   = item_q.link_ok;
    ctrl.reg_value = item_q.reg_value;
    ctrl.ack       = flag_d;
    ctrl.blink     = phase_d[0];

    // The acknowledge wins over a new alarm raised in the same word.
    if (flag_d) begin
      bell_d = 1'b0;
    end else if (|lane_raise) begin
      bell_d = 1'b1;
    end else begin
      bell_d = bell_q;
    end
  end

  for (genvar i = 0; i < MAX_SLAVES; i++) begin : g_lane
    assign lane_en[i]  = 32'(active_n) > i;
    assign lane_sel[i] = ~is_tick & lane_en[i] & (32'(item_q.slave_index) == i);

    saa_slave #(
      .REG_WIDTH(REG_WIDTH)
    ) u_slave (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sel_i    (lane_sel[i]),
      .enabled_i(lane_en[i]),
      .state_d_o(lane_state[i]),
      .raise_o  (lane_raise[i]),
      .lit_o    (lane_lit[i])
    );
  end

  for (genvar j = 0; j < saa_pkg::MASK_W; j++) begin : g_mask
    if (j < MAX_SLAVES) begin : g_used
      assign mask[j] = lane_lit[j];
    end else begin : g_unused
      assign mask[j] = 1'b0;
    end
  end

  // The addressed slave's state; each lane matches at most once.
  always_comb begin
    st_sel = 2'd0;
    for (int k = 0; k < MAX_SLAVES; k++) begin
      if (32'(item_q.slave_index) == k) begin
        st_sel = st_sel | lane_state[k];
      end
    end
    if (!idx_active) begin
      st_sel = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      bell_q       <= 1'b0;
      flag_q       <= 1'b0;
      debounce_q   <= saa_pkg::DEBOUNCE_TICKS_RST;
      blink_q      <= saa_pkg::BLINK_TICKS_RST;
      phase_q      <= 2'd0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= item_valid_q;
      end
      if (update) begin
        bell_q     <= bell_d;
        flag_q     <= flag_d;
        debounce_q <= debounce_d;
        blink_q    <= blink_d;
        phase_q    <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (update) begin
      out_q.led_on_mask  <= mask;
      out_q.buzzer_on    <= bell_d & phase_d[1];
      out_q.bell_active  <= bell_d;
      out_q.reset_active <= flag_d;
      out_q.slave_state  <= st_sel;
    end
  end

endmodule
